// ----- rtl/sart_pkg.sv -----
// ----------------------------------------------------------------------------
// sart_pkg: shared types and constants of the summed-area rectangle sum unit
// Sizes, field codes and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package sart_pkg;

	// matrix and arithmetic sizes
	localparam int MAX_ROWS     = 1024;
	localparam int MAX_COLS     = 1024;
	localparam int ELEMENT_BITS = 32;
	localparam int SUM_BITS     = 52;
	localparam int ROW_BITS     = 10;
	localparam int COL_BITS     = 10;
	localparam int DIM_BITS     = 11;
	localparam int ADDR_BITS    = ROW_BITS + COL_BITS;
	localparam int TABLE_DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int STAT_BITS    = 2;

	// stream and config port widths
	localparam int S_TDATA_BITS = 72;
	localparam int M_TDATA_BITS = 56;
	localparam int CFG_IDX_BITS = 2;

	// input kinds
	localparam logic ACTION_LOAD  = 1'b0;
	localparam logic ACTION_QUERY = 1'b1;

	// query status codes
	localparam logic [STAT_BITS-1:0] STAT_OK          = 2'd0;
	localparam logic [STAT_BITS-1:0] STAT_BAD_CORNERS = 2'd1;
	localparam logic [STAT_BITS-1:0] STAT_NOT_LOADED  = 2'd2;

	// config register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_COL_COUNT = 2'd1;

	// table address selects
	typedef logic [2:0] addr_sel_t;
	localparam addr_sel_t ADDR_POS    = 3'd0;
	localparam addr_sel_t ADDR_ABOVE  = 3'd1;
	localparam addr_sel_t ADDR_BIG    = 3'd2;
	localparam addr_sel_t ADDR_TOP    = 3'd3;
	localparam addr_sel_t ADDR_LEFT   = 3'd4;
	localparam addr_sel_t ADDR_CORNER = 3'd5;

	// accumulator operations
	typedef logic [2:0] acc_op_t;
	localparam acc_op_t ACC_HOLD       = 3'd0;
	localparam acc_op_t ACC_LOAD       = 3'd1;
	localparam acc_op_t ACC_SUB_TOP    = 3'd2;
	localparam acc_op_t ACC_SUB_LEFT   = 3'd3;
	localparam acc_op_t ACC_ADD_CORNER = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic      capture;
		logic      rs_add;
		logic      ld_commit;
		logic      mem_we;
		addr_sel_t addr_sel;
		acc_op_t   acc_op;
		logic      stat_latch;
		logic      out_load;
	} sart_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic q_err;
		logic out_free;
	} sart_sts_t;

	// zero reads as one, values above the maximum read as the maximum
	function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
		input logic [DIM_BITS-1:0] maxv);
		logic [DIM_BITS-1:0] r;
		if (v == '0) begin
			r = DIM_BITS'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ----- rtl/sart_ram.sv -----
// ----------------------------------------------------------------------------
// sart_ram: generic single-port RAM
// One access per cycle, write or read, read data registered.
// ----------------------------------------------------------------------------
module sart_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write or registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

// ----- rtl/sart_ctrl.sv -----
// ----------------------------------------------------------------------------
// sart_ctrl: sequencer of the summed-area rectangle sum unit
// Steps a load through read-above and write, and a query through four reads.
// ----------------------------------------------------------------------------
module sart_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic               action,
	input  sart_pkg::sart_sts_t sts,
	output sart_pkg::sart_cmd_t cmd
);
	import sart_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LRD  = 4'd1;
	localparam logic [3:0] ST_LWR  = 4'd2;
	localparam logic [3:0] ST_Q0   = 4'd3;
	localparam logic [3:0] ST_Q1   = 4'd4;
	localparam logic [3:0] ST_Q2   = 4'd5;
	localparam logic [3:0] ST_Q3   = 4'd6;
	localparam logic [3:0] ST_Q4   = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       s_accept;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;

	// next state and commands
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.addr_sel   = ADDR_POS;
		cmd.acc_op     = ACC_HOLD;
		case (state_q)
			ST_IDLE: begin
				cmd.capture = s_accept;
				if (s_accept) begin
					state_d = (action == ACTION_QUERY) ? ST_Q0 : ST_LRD;
				end
			end
			ST_LRD: begin
				cmd.addr_sel = ADDR_ABOVE;
				cmd.rs_add   = 1'b1;
				state_d      = ST_LWR;
			end
			ST_LWR: begin
				cmd.addr_sel  = ADDR_POS;
				cmd.mem_we    = 1'b1;
				cmd.ld_commit = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_Q0: begin
				cmd.addr_sel   = ADDR_BIG;
				cmd.stat_latch = 1'b1;
				state_d        = sts.q_err ? ST_DONE : ST_Q1;
			end
			ST_Q1: begin
				cmd.addr_sel = ADDR_TOP;
				cmd.acc_op   = ACC_LOAD;
				state_d      = ST_Q2;
			end
			ST_Q2: begin
				cmd.addr_sel = ADDR_LEFT;
				cmd.acc_op   = ACC_SUB_TOP;
				state_d      = ST_Q3;
			end
			ST_Q3: begin
				cmd.addr_sel = ADDR_CORNER;
				cmd.acc_op   = ACC_SUB_LEFT;
				state_d      = ST_Q4;
			end
			ST_Q4: begin
				cmd.acc_op = ACC_ADD_CORNER;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				// hand the result over once the output register is free
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// table writes happen only in the load write step
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_we |-> (state_q == ST_LWR))
		else $error("table write outside load write step");

	// an accepted item always leaves idle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> (state_q == ST_LRD || state_q == ST_Q0))
		else $error("accepted item did not start a sequence");

	// a result is only produced at the end of a query
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (state_q == ST_DONE && sts.out_free))
		else $error("result loaded outside done step");

endmodule

// ----- rtl/sart_dp.sv -----
// ----------------------------------------------------------------------------
// sart_dp: datapath of the summed-area rectangle sum unit
// Config registers, load position, running row sum, prefix table, accumulator
// and the output register.
// ----------------------------------------------------------------------------
module sart_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [sart_pkg::S_TDATA_BITS-1:0]     s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [sart_pkg::M_TDATA_BITS-1:0]     m_tdata,
	input  logic                                  cfg_we,
	input  logic [sart_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [sart_pkg::DIM_BITS-1:0]         cfg_data,
	input  sart_pkg::sart_cmd_t                   cmd,
	output sart_pkg::sart_sts_t                   sts
);
	import sart_pkg::*;

	localparam logic [DIM_BITS-1:0] MAX_ROWS_D = DIM_BITS'(MAX_ROWS);
	localparam logic [DIM_BITS-1:0] MAX_COLS_D = DIM_BITS'(MAX_COLS);

	// config and load state
	logic [DIM_BITS-1:0]     row_cnt_q;
	logic [DIM_BITS-1:0]     col_cnt_q;
	logic [ROW_BITS-1:0]     load_row_q;
	logic [COL_BITS-1:0]     load_col_q;
	logic [SUM_BITS-1:0]     rs_q;
	logic                    ready_q;

	// captured item
	logic [ELEMENT_BITS-1:0] elem_q;
	logic [ROW_BITS-1:0]     top_q;
	logic [COL_BITS-1:0]     left_q;
	logic [ROW_BITS-1:0]     bot_q;
	logic [COL_BITS-1:0]     right_q;

	// query state
	logic [SUM_BITS-1:0]     acc_q;
	logic [STAT_BITS-1:0]    qstat_q;
	logic [STAT_BITS-1:0]    qstat_d;
	logic                    bad_corners;

	// output register
	logic                    m_valid_q;
	logic [SUM_BITS-1:0]     m_sum_q;
	logic [STAT_BITS-1:0]    m_stat_q;

	// table port
	logic                    mem_we;
	logic [ADDR_BITS-1:0]    mem_addr;
	logic [SUM_BITS-1:0]     mem_wdata;
	logic [SUM_BITS-1:0]     mem_rdata;

	logic [ROW_BITS-1:0]     top_m1;
	logic [COL_BITS-1:0]     left_m1;
	logic [ROW_BITS-1:0]     load_row_m1;
	logic [DIM_BITS-1:0]     col_inc;
	logic [DIM_BITS-1:0]     row_inc;
	logic [SUM_BITS-1:0]     elem_ext;
	logic [SUM_BITS-1:0]     above;
	logic                    load_last;

	assign top_m1      = top_q - ROW_BITS'(1);
	assign left_m1     = left_q - COL_BITS'(1);
	assign load_row_m1 = load_row_q - ROW_BITS'(1);
	assign col_inc     = {1'b0, load_col_q} + DIM_BITS'(1);
	assign row_inc     = {1'b0, load_row_q} + DIM_BITS'(1);
	assign elem_ext    = {{(SUM_BITS-ELEMENT_BITS){elem_q[ELEMENT_BITS-1]}}, elem_q};
	assign above       = (load_row_q != '0) ? mem_rdata : '0;
	assign load_last   = (col_inc >= col_cnt_q) && (row_inc >= row_cnt_q);

	// table address select
	always_comb begin
		case (cmd.addr_sel)
			ADDR_POS:    mem_addr = {load_row_q, load_col_q};
			ADDR_ABOVE:  mem_addr = {load_row_m1, load_col_q};
			ADDR_BIG:    mem_addr = {bot_q, right_q};
			ADDR_TOP:    mem_addr = {top_m1, right_q};
			ADDR_LEFT:   mem_addr = {bot_q, left_m1};
			ADDR_CORNER: mem_addr = {top_m1, left_m1};
			default:     mem_addr = {load_row_q, load_col_q};
		endcase
	end

	assign mem_we    = cmd.mem_we;
	assign mem_wdata = rs_q + above;

	sart_ram #(
		.WIDTH (SUM_BITS),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// corner check and query status
	assign bad_corners = (top_q > bot_q) || (left_q > right_q) ||
		({1'b0, bot_q} >= row_cnt_q) || ({1'b0, right_q} >= col_cnt_q);

	always_comb begin
		if (!ready_q) begin
			qstat_d = STAT_NOT_LOADED;
		end else if (bad_corners) begin
			qstat_d = STAT_BAD_CORNERS;
		end else begin
			qstat_d = STAT_OK;
		end
	end

	assign sts.q_err    = (qstat_d != STAT_OK);
	assign sts.out_free = !m_valid_q || m_tready;

	// config registers, load position, running sum, ready flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q  <= DIM_BITS'(1);
			col_cnt_q  <= DIM_BITS'(1);
			load_row_q <= '0;
			load_col_q <= '0;
			rs_q       <= '0;
			ready_q    <= 1'b0;
		end else if (cfg_we && (cfg_index == REG_ROW_COUNT || cfg_index == REG_COL_COUNT)) begin
			if (cfg_index == REG_ROW_COUNT) begin
				row_cnt_q <= clamp_dim(cfg_data, MAX_ROWS_D);
			end else begin
				col_cnt_q <= clamp_dim(cfg_data, MAX_COLS_D);
			end
			load_row_q <= '0;
			load_col_q <= '0;
			rs_q       <= '0;
			ready_q    <= 1'b0;
		end else if (cmd.rs_add) begin
			rs_q <= rs_q + elem_ext;
		end else if (cmd.ld_commit) begin
			// the last load completes the matrix, a load at the origin starts a new one
			if (load_last) begin
				ready_q <= 1'b1;
			end else if (load_row_q == '0 && load_col_q == '0) begin
				ready_q <= 1'b0;
			end
			if (col_inc >= col_cnt_q) begin
				load_col_q <= '0;
				rs_q       <= '0;
				load_row_q <= load_last ? '0 : row_inc[ROW_BITS-1:0];
			end else begin
				load_col_q <= col_inc[COL_BITS-1:0];
			end
		end
	end

	// item capture, tdata packed element, top, left, bottom, right
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			elem_q  <= s_tdata[31:0];
			top_q   <= s_tdata[41:32];
			left_q  <= s_tdata[51:42];
			bot_q   <= s_tdata[61:52];
			right_q <= s_tdata[71:62];
		end
	end

	// inclusion-exclusion accumulator, missing terms count as zero
	always_ff @(posedge clk) begin
		if (cmd.stat_latch) begin
			qstat_q <= qstat_d;
		end
		case (cmd.acc_op)
			ACC_LOAD: acc_q <= mem_rdata;
			ACC_SUB_TOP: begin
				if (top_q != '0) begin
					acc_q <= acc_q - mem_rdata;
				end
			end
			ACC_SUB_LEFT: begin
				if (left_q != '0) begin
					acc_q <= acc_q - mem_rdata;
				end
			end
			ACC_ADD_CORNER: begin
				if (top_q != '0 && left_q != '0) begin
					acc_q <= acc_q + mem_rdata;
				end
			end
			default: acc_q <= acc_q;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_sum_q  <= (qstat_q == STAT_OK) ? acc_q : '0;
			m_stat_q <= qstat_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_TDATA_BITS-SUM_BITS-STAT_BITS){1'b0}}, m_stat_q, m_sum_q};

	// load position stays inside the configured grid
	assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, load_row_q} < row_cnt_q) && ({1'b0, load_col_q} < col_cnt_q))
		else $error("load position outside configured grid");

	// configured sizes stay within one and the maximum
	assert property (@(posedge clk) disable iff (!arst_n)
		row_cnt_q != '0 && row_cnt_q <= MAX_ROWS_D &&
		col_cnt_q != '0 && col_cnt_q <= MAX_COLS_D)
		else $error("configured size out of range");

	// a result loaded with an error status carries a zero sum
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_stat_q != STAT_OK) |-> (m_sum_q == '0))
		else $error("error result with nonzero sum");

endmodule

// ----- rtl/summed_area_rectangle_sum_unit.sv -----
// ----------------------------------------------------------------------------
// summed_area_rectangle_sum_unit: summed-area table with rectangle queries
// Builds a prefix-sum table from row-major loads and answers rectangle sums.
//
//   channel  direction  transfer when        carries
//   s_*      in         s_tvalid & s_tready  tuser action, tdata element and corners
//   m_*      out        m_tvalid & m_tready  tdata region sum and status
//   cfg_*    in         cfg_we               row_count (0), col_count (1)
//
// A load steps through accept, read above and write, a query through accept,
// four table reads, last add and result, and one that fails its checks through
// accept, status check and result; the single-port table memory sets these steps.
// arst_n clears the sizes to 1x1, the load position and the ready flag; the
// table content is undefined until loaded.
// A query whose result finds the output register full waits in its last step;
// the input side stays closed until then.
// ----------------------------------------------------------------------------
module summed_area_rectangle_sum_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// element_value[31:0], top_row[41:32], left_col[51:42],
	// bottom_row[61:52], right_col[71:62]
	input  logic [sart_pkg::S_TDATA_BITS-1:0]     s_tdata,
	// action[0]
	input  logic                                  s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// region_sum[51:0], query_status[53:52], zero pad[55:54]
	output logic [sart_pkg::M_TDATA_BITS-1:0]     m_tdata,
	input  logic                                  cfg_we,
	input  logic [sart_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [sart_pkg::DIM_BITS-1:0]         cfg_data
);
	import sart_pkg::*;

	sart_cmd_t cmd;
	sart_sts_t sts;

	// sequencer
	sart_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.action   (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath and table
	sart_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
